// ===== design/fvlb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the four-vector Lorentz boost.
// No dependencies; imported by four_vector_lorentz_boost.
package fvlb_pkg;

    typedef logic signed [63:0] t_s64;
    typedef logic [63:0]        t_u64;

    // Width of the gamma field, bits of quotient per divider stage, divider widths
    localparam int VEL_T_W  = 31;
    localparam int DIV_STEP = 4;
    localparam int DEN_W    = 34;
    localparam int REM_W    = 35;

    // Clip level for products and quotients
    localparam t_u64 CLIP   = 64'h4000_0000_0000_0000;

    // Context that travels with an item down the pipeline
    typedef struct packed {
        logic             cmd;
        logic             ov;
        logic [3:0][63:0] p;
        logic [3:0][63:0] umag;
        logic [3:0]       uneg;
        logic [63:0]      pu;
    } t_ctx;

    // Signed 64-bit add that saturates; returns {overflow, sum}
    function automatic logic [64:0] sat_add(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            return {1'b1, s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
        end
        return {1'b0, s[63:0]};
    endfunction

    // Magnitude of a signed 64-bit value as unsigned
    function automatic t_u64 mag(input t_s64 a);
        t_s64 n;
        n = -a;
        return a[63] ? t_u64'(n) : t_u64'(a);
    endfunction

endpackage

// ===== design/four_vector_lorentz_boost.sv =====
`timescale 1ns / 1ps
// Four-vector Lorentz boost: streaming pipeline with split multipliers and a
// pipelined long divider. Depends on fvlb_pkg.
// The divider retires four quotient bits a stage.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (i_rst_n low, synchronous) clears the stage valid bits; data is not reset.
module four_vector_lorentz_boost
    import fvlb_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int IN_W      = ((VEL_T_W + 7 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((4 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // vel_t, vel_x, vel_y, vel_z, mom_t, mom_x, mom_y, mom_z (lowest bit up), zero pad
    input  logic [IN_W-1:0]       i_s_axis_tdata,
    // command
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_t, out_x, out_y, out_z (lowest bit up), zero pad
    output logic [OUT_W-1:0]      o_m_axis_tdata,
    // overflow
    output logic                  o_m_axis_tuser
);

    localparam int NB     = 64 + FRAC_BITS;
    localparam int DS     = (NB + DIV_STEP - 1) / DIV_STEP;
    localparam int NSTG   = 13 + DS;
    localparam int ST_H   = 6 + DS;
    localparam t_s64 OUT_MAX = t_s64'((65'(1) << (DATA_WIDTH - 1)) - 65'(1));
    localparam t_s64 OUT_MIN = -OUT_MAX - 64'sd1;
    localparam t_s64 CLIP_S  = t_s64'(CLIP);

    // Combine four 32x32 partial products, drop fraction bits, clip, apply sign
    function automatic logic [64:0] mul_fin(input logic [3:0][63:0] pp, input logic neg);
        logic [127:0] full;
        logic [127:0] v;
        logic [63:0]  r;
        logic         ov;
        full = 128'(pp[0]) + (128'(pp[1]) << 32) + (128'(pp[2]) << 32)
             + (128'(pp[3]) << 64);
        v  = full >> FRAC_BITS;
        ov = (v > 128'(CLIP));
        r  = ov ? CLIP : v[63:0];
        if (neg) begin
            r = -r;
        end
        return {ov, r};
    endfunction

    // Clip to the output width; returns {overflow, value}
    function automatic logic [DATA_WIDTH:0] sat_out(input t_s64 v);
        if (v > OUT_MAX) begin
            return {1'b1, OUT_MAX[DATA_WIDTH-1:0]};
        end
        if (v < OUT_MIN) begin
            return {1'b1, OUT_MIN[DATA_WIDTH-1:0]};
        end
        return {1'b0, v[DATA_WIDTH-1:0]};
    endfunction

    logic                  w_adv;
    logic                  r_vld [NSTG];
    t_ctx                  r_ctx [NSTG-1];
    t_ctx                  n_ctx [NSTG-1];
    t_s64                  w_u [4];
    t_s64                  w_p [4];

    logic [63:0]           r_a_pmag [4], n_a_pmag [4];
    logic [3:0]            r_a_pneg, n_a_pneg;
    logic [3:0][63:0]      r_b_pp [4], n_b_pp [4];
    logic [3:0]            r_b_neg, n_b_neg;
    t_s64                  r_c_m [4], n_c_m [4];
    t_s64                  r_d_s, n_d_s, r_d_m3, n_d_m3;
    t_s64                  r_e_num, n_e_num;
    logic [NB-1:0]         r_dv_dvd [DS+1], n_dv_dvd [DS+1];
    logic [REM_W-1:0]      r_dv_rem [DS+1], n_dv_rem [DS+1];
    logic [63:0]           r_dv_quo [DS+1], n_dv_quo [DS+1];
    logic [DEN_W-1:0]      r_dv_den [DS+1], n_dv_den [DS+1];
    logic                  r_dv_neg [DS+1], n_dv_neg [DS+1];
    t_s64                  r_h_a, n_h_a, r_h_d2, n_h_d2;
    t_s64                  r_i_mc, n_i_mc, r_i_ta, n_i_ta;
    logic [63:0]           r_j_mmag, n_j_mmag;
    logic                  r_j_mneg, n_j_mneg;
    t_s64                  r_j_ta, n_j_ta;
    logic [3:0][63:0]      r_k_pp [4], n_k_pp [4];
    logic [3:0]            r_k_neg, n_k_neg;
    t_s64                  r_k_ta, n_k_ta;
    t_s64                  r_l_prod [4], n_l_prod [4];
    t_s64                  r_l_ta, n_l_ta;
    t_s64                  r_m_r [4], n_m_r [4];
    t_s64                  r_m_ta, n_m_ta;
    logic [DATA_WIDTH-1:0] r_out [4], n_out [4];
    logic                  r_out_ov, n_out_ov;

    // Advance every stage together unless a result is held at the output
    assign w_adv           = !r_vld[NSTG-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = OUT_W'({r_out[3], r_out[2], r_out[1], r_out[0]});
    assign o_m_axis_tuser  = r_out_ov;

    // Unpack the input transfer into 64-bit signed components
    always_comb begin
        w_u[0] = t_s64'(64'(i_s_axis_tdata[VEL_T_W-1:0]));
        w_p[0] = 64'($signed(i_s_axis_tdata[VEL_T_W + 3*DATA_WIDTH +: DATA_WIDTH]));
        for (int i = 1; i < 4; i++) begin
            w_u[i] = 64'($signed(i_s_axis_tdata[VEL_T_W + (i-1)*DATA_WIDTH +: DATA_WIDTH]));
            w_p[i] = 64'($signed(i_s_axis_tdata[VEL_T_W + (i+3)*DATA_WIDTH +: DATA_WIDTH]));
        end
    end

    // Next values for all stages
    always_comb begin
        logic [64:0]      t1;
        logic [64:0]      t2;
        logic [REM_W-1:0] rem;
        logic [NB-1:0]    dvd;
        logic [63:0]      quo;
        logic [63:0]      qc;
        logic             qov;
        logic [DATA_WIDTH:0] so;

        // Pass context on by default
        for (int k = 1; k < NSTG - 1; k++) begin
            n_ctx[k] = r_ctx[k-1];
        end

        // Stage A: sign-extend, take magnitudes
        n_ctx[0].cmd = i_s_axis_tuser;
        n_ctx[0].ov  = 1'b0;
        n_ctx[0].pu  = '0;
        for (int i = 0; i < 4; i++) begin
            n_ctx[0].p[i]    = w_p[i];
            n_ctx[0].umag[i] = mag(w_u[i]);
            n_ctx[0].uneg[i] = w_u[i][63];
            n_a_pmag[i]      = mag(w_p[i]);
            n_a_pneg[i]      = w_p[i][63];
        end

        // Stage B: partial products of p times u
        for (int i = 0; i < 4; i++) begin
            n_b_pp[i][0] = 64'(r_a_pmag[i][31:0])  * 64'(r_ctx[0].umag[i][31:0]);
            n_b_pp[i][1] = 64'(r_a_pmag[i][31:0])  * 64'(r_ctx[0].umag[i][63:32]);
            n_b_pp[i][2] = 64'(r_a_pmag[i][63:32]) * 64'(r_ctx[0].umag[i][31:0]);
            n_b_pp[i][3] = 64'(r_a_pmag[i][63:32]) * 64'(r_ctx[0].umag[i][63:32]);
            n_b_neg[i]   = r_a_pneg[i] ^ r_ctx[0].uneg[i];
        end

        // Stage C: finish products
        for (int i = 0; i < 4; i++) begin
            t1 = mul_fin(r_b_pp[i], r_b_neg[i]);
            n_c_m[i] = t1[63:0];
            n_ctx[2].ov = n_ctx[2].ov | t1[64];
        end

        // Stage D: first three terms of the Minkowski product
        t1 = sat_add(r_c_m[0], -r_c_m[1]);
        t2 = sat_add(t1[63:0], -r_c_m[2]);
        n_d_s  = t2[63:0];
        n_d_m3 = r_c_m[3];
        n_ctx[3].ov = r_ctx[2].ov | t1[64] | t2[64];

        // Stage E: last term, numerator
        t1 = sat_add(r_d_s, -r_d_m3);
        t2 = sat_add(t1[63:0], r_ctx[3].p[0]);
        n_ctx[4].pu = t1[63:0];
        n_e_num     = t2[63:0];
        n_ctx[4].ov = r_ctx[3].ov | t1[64] | t2[64];

        // Stage F: load the divider
        n_dv_dvd[0] = NB'(mag(r_e_num)) << FRAC_BITS;
        n_dv_rem[0] = '0;
        n_dv_quo[0] = '0;
        n_dv_den[0] = (DEN_W'(1) << FRAC_BITS) + DEN_W'(r_ctx[4].umag[0]);
        n_dv_neg[0] = r_e_num[63];

        // Divider stages: restoring long division, four bits each
        for (int s = 1; s <= DS; s++) begin
            rem = r_dv_rem[s-1];
            dvd = r_dv_dvd[s-1];
            quo = r_dv_quo[s-1];
            for (int k = 0; k < DIV_STEP; k++) begin
                if ((s - 1) * DIV_STEP + k < NB) begin
                    rem = {rem[REM_W-2:0], dvd[NB-1]};
                    dvd = dvd << 1;
                    if (rem >= REM_W'(r_dv_den[s-1])) begin
                        rem = rem - REM_W'(r_dv_den[s-1]);
                        quo = {quo[62:0], 1'b1};
                    end else begin
                        quo = {quo[62:0], 1'b0};
                    end
                end
            end
            n_dv_rem[s] = rem;
            n_dv_dvd[s] = dvd;
            n_dv_quo[s] = quo;
            n_dv_den[s] = r_dv_den[s-1];
            n_dv_neg[s] = r_dv_neg[s-1];
        end

        // Stage H: clip quotient, form A; doubled term in parallel
        qov    = r_dv_quo[DS] > CLIP;
        qc     = qov ? CLIP : r_dv_quo[DS];
        n_h_a  = r_dv_neg[DS] ? t_s64'(qc) : -t_s64'(qc);
        if (r_ctx[ST_H-1].cmd) begin
            t1 = sat_add(r_ctx[ST_H-1].pu, r_ctx[ST_H-1].pu);
        end else begin
            t1 = sat_add(r_ctx[ST_H-1].p[0], r_ctx[ST_H-1].p[0]);
        end
        n_h_d2 = t1[63:0];
        n_ctx[ST_H].ov = r_ctx[ST_H-1].ov | qov | t1[64];

        // Stage I: coefficient, steer to multiplier and time term
        t1 = sat_add(r_h_a, r_h_d2);
        n_i_mc = r_ctx[ST_H].cmd ? r_h_a : t1[63:0];
        n_i_ta = r_ctx[ST_H].cmd ? t1[63:0] : r_h_a;
        n_ctx[ST_H+1].ov = r_ctx[ST_H].ov | t1[64];

        // Stage J: magnitude of the coefficient
        n_j_mmag = mag(r_i_mc);
        n_j_mneg = r_i_mc[63];
        n_j_ta   = r_i_ta;

        // Stage K: partial products of coefficient times u
        for (int i = 0; i < 4; i++) begin
            n_k_pp[i][0] = 64'(r_j_mmag[31:0])  * 64'(r_ctx[ST_H+2].umag[i][31:0]);
            n_k_pp[i][1] = 64'(r_j_mmag[31:0])  * 64'(r_ctx[ST_H+2].umag[i][63:32]);
            n_k_pp[i][2] = 64'(r_j_mmag[63:32]) * 64'(r_ctx[ST_H+2].umag[i][31:0]);
            n_k_pp[i][3] = 64'(r_j_mmag[63:32]) * 64'(r_ctx[ST_H+2].umag[i][63:32]);
            n_k_neg[i]   = r_j_mneg ^ r_ctx[ST_H+2].uneg[i];
        end
        n_k_ta = r_j_ta;

        // Stage L: finish products
        for (int i = 0; i < 4; i++) begin
            t1 = mul_fin(r_k_pp[i], r_k_neg[i]);
            n_l_prod[i] = t1[63:0];
            n_ctx[ST_H+4].ov = n_ctx[ST_H+4].ov | t1[64];
        end
        n_l_ta = r_k_ta;

        // Stage M: add products to p
        for (int i = 0; i < 4; i++) begin
            t1 = sat_add(r_ctx[ST_H+4].p[i], r_l_prod[i]);
            n_m_r[i] = t1[63:0];
            n_ctx[ST_H+5].ov = n_ctx[ST_H+5].ov | t1[64];
        end
        n_m_ta = r_l_ta;

        // Stage N: time term, clip to output width
        n_out_ov = r_ctx[NSTG-2].ov;
        t1 = sat_add(r_m_r[0], r_m_ta);
        n_out_ov = n_out_ov | t1[64];
        for (int i = 0; i < 4; i++) begin
            so = sat_out((i == 0) ? t_s64'(t1[63:0]) : r_m_r[i]);
            n_out[i] = so[DATA_WIDTH-1:0];
            n_out_ov = n_out_ov | so[DATA_WIDTH];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NSTG - 1; k++) begin
                r_ctx[k] <= n_ctx[k];
            end
            for (int s = 0; s <= DS; s++) begin
                r_dv_dvd[s] <= n_dv_dvd[s];
                r_dv_rem[s] <= n_dv_rem[s];
                r_dv_quo[s] <= n_dv_quo[s];
                r_dv_den[s] <= n_dv_den[s];
                r_dv_neg[s] <= n_dv_neg[s];
            end
            for (int i = 0; i < 4; i++) begin
                r_a_pmag[i] <= n_a_pmag[i];
                r_b_pp[i]   <= n_b_pp[i];
                r_c_m[i]    <= n_c_m[i];
                r_k_pp[i]   <= n_k_pp[i];
                r_l_prod[i] <= n_l_prod[i];
                r_m_r[i]    <= n_m_r[i];
                r_out[i]    <= n_out[i];
            end
            r_a_pneg <= n_a_pneg;
            r_b_neg  <= n_b_neg;
            r_d_s    <= n_d_s;
            r_d_m3   <= n_d_m3;
            r_e_num  <= n_e_num;
            r_h_a    <= n_h_a;
            r_h_d2   <= n_h_d2;
            r_i_mc   <= n_i_mc;
            r_i_ta   <= n_i_ta;
            r_j_mmag <= n_j_mmag;
            r_j_mneg <= n_j_mneg;
            r_j_ta   <= n_j_ta;
            r_k_neg  <= n_k_neg;
            r_k_ta   <= n_k_ta;
            r_l_ta   <= n_l_ta;
            r_m_ta   <= n_m_ta;
            r_out_ov <= n_out_ov;
        end
    end

    // Divider remainder always stays below the divisor
    for (genvar g = 1; g <= DS; g++) begin : g_rem_chk
        a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[5+g] |-> (r_dv_rem[g] < REM_W'(r_dv_den[g])))
            else $error("divider remainder not below divisor");
    end

    // First products never leave the clip range
    a_prod_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_c_m[0] <= CLIP_S && r_c_m[0] >= -CLIP_S
                   && r_c_m[1] <= CLIP_S && r_c_m[1] >= -CLIP_S
                   && r_c_m[2] <= CLIP_S && r_c_m[2] >= -CLIP_S
                   && r_c_m[3] <= CLIP_S && r_c_m[3] >= -CLIP_S))
        else $error("product outside clip range");

    // A clipped quotient must raise the item's overflow flag
    a_quo_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_H-1] && w_adv && r_dv_quo[DS] > CLIP) |=> r_ctx[ST_H].ov)
        else $error("quotient clip lost its overflow flag");

    // An overflow seen before the last stage reaches the output flag
    a_ov_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-2] && w_adv && r_ctx[NSTG-2].ov) |=> r_out_ov)
        else $error("overflow flag dropped at output");

endmodule
